// ----- hdl/dmsq_pkg.sv -----
// Shared types, codes and saturation helper for the density matrix gate core.
package dmsq_pkg;

  // command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_APPLY = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_TARGET = 3'd0;
  localparam logic [2:0] CFG_MASK   = 3'd1;
  localparam logic [2:0] CFG_COEF00 = 3'd2;
  localparam logic [2:0] CFG_COEF01 = 3'd3;
  localparam logic [2:0] CFG_COEF10 = 3'd4;
  localparam logic [2:0] CFG_COEF11 = 3'd5;

  // datapath widths
  localparam int VAL_W  = 18;  // stored element part
  localparam int COEF_W = 16;  // gate coefficient part
  localparam int OPA_W  = 36;  // multiplier operand A
  localparam int OPB_W  = 18;  // multiplier operand B
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W  = 56;
  localparam int WIDE_W = ACC_W + 1;

  localparam int SAT_HI = 131071;
  localparam int SAT_LO = -131072;

  // one step issued to the multiply-accumulate unit
  typedef struct packed {
    logic       valid;
    logic       first;
    logic       last;
    logic [1:0] elem;
  } mac_tag_t;

  // clamp a wide signed value to one stored part
  function automatic logic signed [VAL_W-1:0] sat18(input logic signed [WIDE_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > WIDE_W'(SAT_HI)) begin
      r = VAL_W'(SAT_HI);
    end else if (v < WIDE_W'(SAT_LO)) begin
      r = VAL_W'(SAT_LO);
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/dmsq_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module dmsq_ram #(
  parameter int W = 36,
  parameter int D = 2080
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hdl/dmsq_cmac.sv -----
// Complex multiply-accumulate unit: registered products, then accumulation.
module dmsq_cmac import dmsq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mac_tag_t                 tag_i,
  input  logic signed [OPA_W-1:0]  a_re_i,
  input  logic signed [OPA_W-1:0]  a_im_i,
  input  logic signed [OPB_W-1:0]  b_re_i,
  input  logic signed [OPB_W-1:0]  b_im_i,
  output logic                     done_o,
  output logic [1:0]               elem_o,
  output logic signed [ACC_W-1:0]  acc_re_o,
  output logic signed [ACC_W-1:0]  acc_im_o
);

  mac_tag_t                 tag_q;
  logic signed [PROD_W-1:0] p0_q, p1_q, p2_q, p3_q;
  logic signed [ACC_W-1:0]  acc_re_q, acc_im_q, acc_re_d, acc_im_d;
  logic                     done_q;
  logic [1:0]               elem_q;

  // register the four real products of one step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    p0_q <= a_re_i * b_re_i;
    p1_q <= a_im_i * b_im_i;
    p2_q <= a_re_i * b_im_i;
    p3_q <= a_im_i * b_re_i;
  end

  // combine products and add to the running sum
  always_comb begin
    acc_re_d = (tag_q.first ? '0 : acc_re_q) + (ACC_W'(p0_q) - ACC_W'(p1_q));
    acc_im_d = (tag_q.first ? '0 : acc_im_q) + (ACC_W'(p2_q) + ACC_W'(p3_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= tag_q.valid && tag_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_q.valid) begin
      acc_re_q <= acc_re_d;
      acc_im_q <= acc_im_d;
      elem_q   <= tag_q.elem;
    end
  end

  assign done_o   = done_q;
  assign elem_o   = elem_q;
  assign acc_re_o = acc_re_q;
  assign acc_im_o = acc_im_q;

endmodule

// ----- hdl/density_matrix_single_qubit_gate_core.sv -----
// Density matrix store with element access and in-place single-qubit gate apply.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  command  | start / busy        | command_i, row_i, col_i, value_re_i/_im_i
//  result   | read_valid_o strobe | read_re_o, read_im_o
//  config   | cfg_we_i            | cfg_idx_i, cfg_wdata_i
//
// A read result passes the registered RAM read port and the result register after its beat.
// Apply walks (DIM/2)*(DIM/2+1)/2 blocks: a block outside the controls is skipped; an active
// one runs 4 reads, up to two passes of the single complex multiply-accumulate unit and
// 4 writes, one after another over the one RAM port and the one MAC.
// busy is high during an apply. No clearing pass: the store is undefined until written.
// Reset clears control state and loads the identity gate. Results cannot be stalled.
module density_matrix_single_qubit_gate_core import dmsq_pkg::*; #(
  parameter int NUM_QUBITS = 6
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              command_i,
  input  logic [5:0]              row_i,
  input  logic [5:0]              col_i,
  input  logic signed [VAL_W-1:0] value_re_i,
  input  logic signed [VAL_W-1:0] value_im_i,
  output logic                    read_valid_o,
  output logic signed [VAL_W-1:0] read_re_o,
  output logic signed [VAL_W-1:0] read_im_o,
  input  logic                    cfg_we_i,
  input  logic [2:0]              cfg_idx_i,
  input  logic [31:0]             cfg_wdata_i
);

  localparam int IW    = NUM_QUBITS;
  localparam int DIM   = 1 << NUM_QUBITS;
  localparam int HALF  = DIM / 2;
  localparam int DEPTH = DIM * (DIM + 1) / 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int MW    = (NUM_QUBITS > 6) ? NUM_QUBITS : 6;
  localparam int TW    = 2 * IW + 2;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_RDW   = 3'd3;
  localparam logic [2:0] S_P1    = 3'd4;
  localparam logic [2:0] S_P2    = 3'd5;
  localparam logic [2:0] S_WR    = 3'd6;
  localparam logic [2:0] S_NEXT  = 3'd7;

  localparam logic [3:0] STEPS     = 4'd8;
  localparam logic [3:0] DRAIN_END = 4'd10;

  // lower-triangle address of (r, c) with r >= c
  function automatic logic [AW-1:0] tri_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    logic [IW:0] r1;
    logic [TW-1:0] pr;
    r1 = {1'b0, r} + 1'b1;
    pr = TW'({1'b0, r}) * TW'(r1);
    return AW'((pr >> 1) + TW'(c));
  endfunction

  // configuration registers
  logic [2:0]  target_q;
  logic [5:0]  cmask_q;
  logic [31:0] coef_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= '0;
      cmask_q   <= '0;
      coef_q[0] <= 32'd16384;
      coef_q[1] <= '0;
      coef_q[2] <= '0;
      coef_q[3] <= 32'd16384;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TARGET: target_q  <= cfg_wdata_i[2:0];
        CFG_MASK:   cmask_q   <= cfg_wdata_i[5:0];
        CFG_COEF00: coef_q[0] <= cfg_wdata_i;
        CFG_COEF01: coef_q[1] <= cfg_wdata_i;
        CFG_COEF10: coef_q[2] <= cfg_wdata_i;
        CFG_COEF11: coef_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // sequencer state
  logic [2:0]    st_q, st_d;
  logic [1:0]    k_q, k_d;
  logic [3:0]    s_q, s_d;
  logic [IW-1:0] a_q, a_d, b_q, b_d;

  logic cmd_beat;
  assign busy     = (st_q != S_IDLE);
  assign cmd_beat = start && !busy;

  // command decode
  logic [IW-1:0] c_r, c_c;
  logic          c_in_range, c_conj;
  logic [AW-1:0] c_addr;
  always_comb begin
    c_r        = IW'(row_i);
    c_c        = IW'(col_i);
    c_in_range = (32'(row_i) < DIM) && (32'(col_i) < DIM);
    c_conj     = c_r < c_c;
    c_addr     = c_conj ? tri_addr(c_c, c_r) : tri_addr(c_r, c_c);
  end

  // block indices and control tests
  logic [IW-1:0] tb, low, blk_i, blk_j, blk_p, blk_q;
  logic [MW-1:0] cm;
  logic          row_on, col_on, both_on;
  always_comb begin
    tb      = IW'(1) << target_q;
    low     = tb - 1'b1;
    cm      = MW'(cmask_q) & ~MW'(tb);
    blk_i   = ((a_q & ~low) << 1) | (a_q & low);
    blk_j   = blk_i | tb;
    blk_p   = ((b_q & ~low) << 1) | (b_q & low);
    blk_q   = blk_p | tb;
    row_on  = (MW'(blk_i) & cm) == cm;
    col_on  = (MW'(blk_p) & cm) == cm;
    both_on = row_on && col_on;
  end

  // element of the block visited by the read and write passes
  logic [1:0]    seq_e;
  logic [IW-1:0] e_r, e_c;
  logic          e_conj;
  logic [AW-1:0] e_addr;
  always_comb begin
    unique case (k_q)
      2'd0: seq_e = 2'b00;
      2'd1: seq_e = 2'b11;
      2'd2: seq_e = 2'b10;
      2'd3: seq_e = 2'b01;
    endcase
    e_r    = seq_e[1] ? blk_j : blk_i;
    e_c    = seq_e[0] ? blk_q : blk_p;
    e_conj = e_r < e_c;
    e_addr = e_conj ? tri_addr(e_c, e_r) : tri_addr(e_r, e_c);
  end

  // state transitions
  always_comb begin
    st_d = st_q;
    k_d  = k_q;
    s_d  = s_q;
    a_d  = a_q;
    b_d  = b_q;
    unique case (st_q)
      S_IDLE: begin
        if (cmd_beat && command_i == CMD_APPLY && 32'(target_q) < NUM_QUBITS) begin
          a_d  = '0;
          b_d  = '0;
          st_d = S_SETUP;
        end
      end
      S_SETUP: begin
        k_d  = '0;
        st_d = (row_on || col_on) ? S_RD : S_NEXT;
      end
      S_RD: begin
        k_d = k_q + 1'b1;
        if (k_q == 2'd3) st_d = S_RDW;
      end
      S_RDW: begin
        s_d  = '0;
        st_d = row_on ? S_P1 : S_P2;
      end
      S_P1: begin
        s_d = s_q + 1'b1;
        if (s_q == DRAIN_END) begin
          s_d  = '0;
          k_d  = '0;
          st_d = col_on ? S_P2 : S_WR;
        end
      end
      S_P2: begin
        s_d = s_q + 1'b1;
        if (s_q == DRAIN_END) begin
          k_d  = '0;
          st_d = S_WR;
        end
      end
      S_WR: begin
        k_d = k_q + 1'b1;
        if (k_q == 2'd3) st_d = S_NEXT;
      end
      S_NEXT: begin
        st_d = S_SETUP;
        if (b_q == a_q) begin
          b_d = '0;
          a_d = a_q + 1'b1;
          if (a_q == IW'(HALF - 1)) st_d = S_IDLE;
        end else begin
          b_d = b_q + 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      k_q  <= '0;
      s_q  <= '0;
      a_q  <= '0;
      b_q  <= '0;
    end else begin
      st_q <= st_d;
      k_q  <= k_d;
      s_q  <= s_d;
      a_q  <= a_d;
      b_q  <= b_d;
    end
  end

  // block registers: source, one-sided result, two-sided result
  logic signed [VAL_W-1:0] src_re [4];
  logic signed [VAL_W:0]   src_im [4];
  logic signed [OPA_W-1:0] t_re [4], t_im [4];
  logic signed [ACC_W-1:0] r_re [4], r_im [4];

  // multiply-accumulate step operands
  logic       px, py, pt;
  logic [1:0] src_idx, t_idx;
  logic [1:0] coef_idx;
  mac_tag_t   tag;
  logic signed [OPA_W-1:0] op_a_re, op_a_im;
  logic signed [OPB_W-1:0] op_b_re, op_b_im;
  logic signed [COEF_W-1:0] u_re, u_im;
  always_comb begin
    px       = s_q[2];
    py       = s_q[1];
    pt       = s_q[0];
    src_idx  = (st_q == S_P1) ? {pt, py} : {px, pt};
    t_idx    = (st_q == S_WR) ? seq_e : {px, pt};
    coef_idx = (st_q == S_P1) ? {px, pt} : {py, pt};
    u_re     = $signed(coef_q[coef_idx][15:0]);
    u_im     = $signed(coef_q[coef_idx][31:16]);
    if (st_q == S_P1 || !row_on) begin
      op_a_re = OPA_W'(src_re[src_idx]);
      op_a_im = OPA_W'(src_im[src_idx]);
    end else begin
      op_a_re = t_re[t_idx];
      op_a_im = t_im[t_idx];
    end
    op_b_re = OPB_W'(u_re);
    op_b_im = (st_q == S_P1) ? OPB_W'(u_im) : -OPB_W'(u_im);
    tag.valid = (st_q == S_P1 || st_q == S_P2) && (s_q < STEPS);
    tag.first = !pt;
    tag.last  = pt;
    tag.elem  = {px, py};
  end

  logic                    mac_done;
  logic [1:0]              mac_elem;
  logic signed [ACC_W-1:0] mac_re, mac_im;

  dmsq_cmac u_cmac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tag_i    (tag),
    .a_re_i   (op_a_re),
    .a_im_i   (op_a_im),
    .b_re_i   (op_b_re),
    .b_im_i   (op_b_im),
    .done_o   (mac_done),
    .elem_o   (mac_elem),
    .acc_re_o (mac_re),
    .acc_im_o (mac_im)
  );

  // hold finished sums for the block
  always_ff @(posedge clk_i) begin
    if (mac_done) begin
      if (st_q == S_P1) begin
        t_re[mac_elem] <= mac_re[OPA_W-1:0];
        t_im[mac_elem] <= mac_im[OPA_W-1:0];
      end else begin
        r_re[mac_elem] <= mac_re;
        r_im[mac_elem] <= mac_im;
      end
    end
  end

  // round, conjugate and saturate the element being written back
  logic signed [ACC_W-1:0]  w_re, w_im, rr_re, rr_im;
  logic signed [WIDE_W-1:0] wb_im;
  logic signed [VAL_W-1:0]  wb_re_s, wb_im_s;
  always_comb begin
    w_re  = col_on ? r_re[seq_e] : ACC_W'(t_re[t_idx]);
    w_im  = col_on ? r_im[seq_e] : ACC_W'(t_im[t_idx]);
    rr_re = both_on ? ((w_re + ACC_W'(64'sd134217728)) >>> 28)
                    : ((w_re + ACC_W'(64'sd8192)) >>> 14);
    rr_im = both_on ? ((w_im + ACC_W'(64'sd134217728)) >>> 28)
                    : ((w_im + ACC_W'(64'sd8192)) >>> 14);
    wb_im   = e_conj ? -WIDE_W'(rr_im) : WIDE_W'(rr_im);
    wb_re_s = sat18(WIDE_W'(rr_re));
    wb_im_s = sat18(wb_im);
  end

  // memory port
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [2*VAL_W-1:0]        ram_wdata, ram_rdata;
  logic signed [VAL_W-1:0]   c_im_w;
  always_comb begin
    c_im_w = c_conj ? sat18(WIDE_W'(-(VAL_W+1)'(value_im_i))) : value_im_i;
    if (st_q == S_IDLE) begin
      ram_we    = cmd_beat && command_i == CMD_WRITE && c_in_range;
      ram_waddr = c_addr;
      ram_raddr = c_addr;
      ram_wdata = {c_im_w, value_re_i};
    end else begin
      ram_we    = (st_q == S_WR);
      ram_waddr = e_addr;
      ram_raddr = e_addr;
      ram_wdata = {wb_im_s, wb_re_s};
    end
  end

  dmsq_ram #(
    .W (2 * VAL_W),
    .D (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic signed [VAL_W-1:0] rd_re, rd_im;
  logic signed [VAL_W:0]   rd_im_n;
  assign rd_re   = $signed(ram_rdata[VAL_W-1:0]);
  assign rd_im   = $signed(ram_rdata[2*VAL_W-1:VAL_W]);
  assign rd_im_n = -(VAL_W+1)'(rd_im);

  // track reads in flight
  logic       brd_v_q, crd_v_q;
  logic       brd_conj_q, crd_conj_q, crd_zero_q;
  logic [1:0] brd_e_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brd_v_q <= 1'b0;
      crd_v_q <= 1'b0;
    end else begin
      brd_v_q <= (st_q == S_RD);
      crd_v_q <= cmd_beat && command_i == CMD_READ;
    end
  end

  always_ff @(posedge clk_i) begin
    brd_e_q    <= seq_e;
    brd_conj_q <= e_conj;
    crd_conj_q <= c_conj;
    crd_zero_q <= !c_in_range;
  end

  // capture block source elements
  always_ff @(posedge clk_i) begin
    if (brd_v_q) begin
      src_re[brd_e_q] <= rd_re;
      src_im[brd_e_q] <= brd_conj_q ? rd_im_n : (VAL_W+1)'(rd_im);
    end
  end

  // read result register
  logic                    out_v_q;
  logic signed [VAL_W-1:0] out_re_q, out_im_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= crd_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (crd_v_q) begin
      out_re_q <= crd_zero_q ? '0 : rd_re;
      out_im_q <= crd_zero_q ? '0 : (crd_conj_q ? sat18(WIDE_W'(rd_im_n)) : rd_im);
    end
  end

  assign read_valid_o = out_v_q;
  assign read_re_o    = out_re_q;
  assign read_im_o    = out_im_q;

`ifndef SYNTH
  // a result beat follows a read command through the read tracking and result registers
  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_valid_o |-> $past(start && !busy && command_i == CMD_READ, 2))
    else $error("result beat without a read command");

  // during an apply the store is written only in the write-back pass
  a_write_in_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && busy) |-> (st_q == S_WR))
    else $error("store written outside write-back");

  // finished sums arrive only while a multiply pass runs
  a_mac_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> (st_q == S_P1 || st_q == S_P2))
    else $error("MAC result outside a pass");
`endif

endmodule
